// ===== hdl/assert_macros.svh =====
// assertion macros shared by the list rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define PLL_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list assertion failed");

// consequent in the cycle after the antecedent
`define PLL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list assertion failed");

`endif

// ===== hdl/pll_pkg.sv =====
// types and constants shared by the positional list controller and datapath
package pll_pkg;

   localparam int DEFAULT_DEPTH       = 256;
   localparam int DEFAULT_ENTRY_WIDTH = 32;

   typedef enum logic [2:0] {
      CMD_INSERT   = 3'd0,
      CMD_REMOVE   = 3'd1,
      CMD_RETRIEVE = 3'd2,
      CMD_REPLACE  = 3'd3,
      CMD_CLEAR    = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_SUCCESS     = 2'd0,
      STATUS_RANGE_ERROR = 2'd1,
      STATUS_FAIL        = 2'd2,
      STATUS_OVERFLOW    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ALLOC_POP,
      S_WALK_START,
      S_WALK,
      S_INS_LINK,
      S_INS_FIX,
      S_REM_READ,
      S_REM_FIX,
      S_REM_RELEASE,
      S_RD_WAIT,
      S_REPLACE,
      S_FINISH
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       capture;
      logic       alloc;
      logic       alloc_pop;
      logic       walk_start;
      logic       walk_step;
      logic       link_rd_cur;
      logic       link_wr_slot;
      logic       head_to_slot;
      logic       link_wr_prev_slot;
      logic       head_to_linkq;
      logic       link_wr_prev_linkq;
      logic       release_cur;
      logic       entry_wr_cur;
      logic       count_inc;
      logic       count_dec;
      logic       clear;
      logic       rsp_load;
      logic       rd_use;
      status_type status;
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      cmd_type cmd;
      logic    pos_zero;
      logic    pos_gt_count;
      logic    pos_ge_count;
      logic    count_zero;
      logic    free_avail;
      logic    mark_avail;
      logic    steps_zero;
   } dp_stat_type;

endpackage

// ===== hdl/pll_datapath.sv =====
// datapath of the positional list: slot stores, list pointers, walk and result registers
`include "assert_macros.svh"

module pll_datapath #(
   parameter int DEPTH       = pll_pkg::DEFAULT_DEPTH,
   parameter int ENTRY_WIDTH = pll_pkg::DEFAULT_ENTRY_WIDTH,
   localparam int SLOT_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W      = $clog2(DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pll_pkg::dp_cmd_type     cmd,
   output pll_pkg::dp_stat_type    stat,
   input  logic [2:0]              req_command,
   input  logic [CNT_W-1:0]        req_position,
   input  logic [ENTRY_WIDTH-1:0]  req_new_value,
   output logic [1:0]              rsp_status,
   output logic [ENTRY_WIDTH-1:0]  rsp_read_value,
   output logic [CNT_W-1:0]        rsp_entry_total,
   output logic                    rsp_is_empty
);
   import pll_pkg::*;

   // slot stores
   logic [ENTRY_WIDTH-1:0] entry_mem [DEPTH];
   logic [SLOT_W-1:0]      link_mem  [DEPTH];

   // control registers
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] free_head_ff, free_head_in;
   logic [CNT_W-1:0]  free_len_ff, free_len_in;
   logic [CNT_W-1:0]  mark_ff, mark_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // transaction registers
   cmd_type                cmd_ff, cmd_in;
   logic [CNT_W-1:0]       pos_ff, pos_in;
   logic [ENTRY_WIDTH-1:0] val_ff, val_in;
   logic [CNT_W-1:0]       steps_ff, steps_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SLOT_W-1:0]      cur_ff, cur_in;
   logic [SLOT_W-1:0]      prev_ff, prev_in;
   logic [SLOT_W-1:0]      link_q_ff;
   logic [ENTRY_WIDTH-1:0] entry_q_ff;

   // result registers
   status_type             status_ff, status_in;
   logic [ENTRY_WIDTH-1:0] read_value_ff, read_value_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic                   empty_ff, empty_in;

   logic                   free_avail;
   logic                   steps_zero;
   logic [SLOT_W-1:0]      alloc_slot;
   logic                   link_re, link_we, entry_we;
   logic [SLOT_W-1:0]      link_raddr, link_waddr, link_wdata;
   logic [SLOT_W-1:0]      entry_waddr;
   logic [CNT_W:0]         occupancy;
   logic [CNT_W:0]         mark_wide;

   assign free_avail = (free_len_ff != '0);
   assign steps_zero = (steps_ff == '0);
   assign alloc_slot = free_avail ? free_head_ff : mark_ff[SLOT_W-1:0];
   assign occupancy  = {1'b0, count_ff} + {1'b0, free_len_ff};
   assign mark_wide  = {1'b0, mark_ff};

   assign stat.cmd          = cmd_ff;
   assign stat.pos_zero     = (pos_ff == '0);
   assign stat.pos_gt_count = (pos_ff > count_ff);
   assign stat.pos_ge_count = (pos_ff >= count_ff);
   assign stat.count_zero   = (count_ff == '0);
   assign stat.free_avail   = free_avail;
   assign stat.mark_avail   = (mark_ff < CNT_W'(DEPTH));
   assign stat.steps_zero   = steps_zero;

   // link store read port
   always_comb begin
      link_re    = (cmd.alloc && free_avail) || cmd.link_rd_cur ||
                   ((cmd.walk_start || cmd.walk_step) && !steps_zero);
      link_raddr = cur_ff;
      if (cmd.alloc) begin
         link_raddr = free_head_ff;
      end else if (cmd.walk_start) begin
         link_raddr = head_ff;
      end else if (cmd.walk_step) begin
         link_raddr = link_q_ff;
      end
   end

   // link store write port
   always_comb begin
      link_we    = cmd.link_wr_slot || cmd.link_wr_prev_slot ||
                   cmd.link_wr_prev_linkq || cmd.release_cur;
      link_waddr = cur_ff;
      link_wdata = free_head_ff;
      if (cmd.link_wr_slot) begin
         link_waddr = slot_ff;
         link_wdata = cur_ff;
      end else if (cmd.link_wr_prev_slot) begin
         link_waddr = prev_ff;
         link_wdata = slot_ff;
      end else if (cmd.link_wr_prev_linkq) begin
         link_waddr = prev_ff;
         link_wdata = link_q_ff;
      end
   end

   assign entry_we    = cmd.alloc || cmd.entry_wr_cur;
   assign entry_waddr = cmd.alloc ? alloc_slot : cur_ff;

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_q_ff <= link_mem[link_raddr];
      end
      if (entry_we) begin
         entry_mem[entry_waddr] <= val_ff;
      end
      entry_q_ff <= entry_mem[cur_ff];
   end

   // next values
   always_comb begin
      head_in       = head_ff;
      free_head_in  = free_head_ff;
      free_len_in   = free_len_ff;
      mark_in       = mark_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      steps_in      = steps_ff;
      slot_in       = slot_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      status_in     = status_ff;
      read_value_in = read_value_ff;
      total_in      = total_ff;
      empty_in      = empty_ff;

      if (cmd.capture) begin
         cmd_in   = cmd_type'(req_command);
         pos_in   = req_position;
         val_in   = req_new_value;
         steps_in = req_position;
      end
      if (cmd.alloc) begin
         slot_in = alloc_slot;
         if (!free_avail) begin
            mark_in = mark_ff + CNT_W'(1);
         end
      end
      if (cmd.alloc_pop) begin
         free_head_in = link_q_ff;
         free_len_in  = free_len_ff - CNT_W'(1);
      end
      if (cmd.walk_start) begin
         cur_in = head_ff;
         if (!steps_zero) begin
            steps_in = steps_ff - CNT_W'(1);
         end
      end
      if (cmd.walk_step) begin
         prev_in = cur_ff;
         cur_in  = link_q_ff;
         if (!steps_zero) begin
            steps_in = steps_ff - CNT_W'(1);
         end
      end
      if (cmd.head_to_slot) begin
         head_in = slot_ff;
      end
      if (cmd.head_to_linkq) begin
         head_in = link_q_ff;
      end
      if (cmd.release_cur) begin
         free_head_in = cur_ff;
         free_len_in  = free_len_ff + CNT_W'(1);
      end
      if (cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.clear) begin
         head_in      = '0;
         free_head_in = '0;
         free_len_in  = '0;
         mark_in      = '0;
         count_in     = '0;
      end
      if (cmd.rsp_load) begin
         status_in     = cmd.status;
         read_value_in = cmd.rd_use ? entry_q_ff : '0;
         total_in      = count_ff;
         empty_in      = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         free_head_ff <= '0;
         free_len_ff  <= '0;
         mark_ff      <= '0;
         count_ff     <= '0;
      end else begin
         head_ff      <= head_in;
         free_head_ff <= free_head_in;
         free_len_ff  <= free_len_in;
         mark_ff      <= mark_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      steps_ff      <= steps_in;
      slot_ff       <= slot_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      status_ff     <= status_in;
      read_value_ff <= read_value_in;
      total_ff      <= total_in;
      empty_ff      <= empty_in;
   end

   assign rsp_status      = status_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_entry_total = total_ff;
   assign rsp_is_empty    = empty_ff;

   // listed plus freed slots never exceed the slots handed out
   `PLL_ASSERT_IMPL(a_slot_accounting, clock, reset, 1'b1, occupancy <= mark_wide)
   `PLL_ASSERT_IMPL(a_mark_bounded, clock, reset, 1'b1, mark_ff <= CNT_W'(DEPTH))
   `PLL_ASSERT_IMPL(a_alloc_has_slot, clock, reset, cmd.alloc, stat.free_avail || stat.mark_avail)

endmodule

// ===== hdl/pll_ctrl.sv =====
// controller state machine of the positional list
`include "assert_macros.svh"

module pll_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pll_pkg::dp_stat_type stat,
   output pll_pkg::dp_cmd_type  cmd
);
   import pll_pkg::*;

   state_type  state_ff, state_in;
   status_type pend_ff, pend_in;
   logic       rd_use_ff, rd_use_in;
   logic       rsp_valid_ff, rsp_valid_in;
   state_type  after_walk;

   // work that follows the walk to the wanted position
   always_comb begin
      unique case (stat.cmd)
         CMD_INSERT:   after_walk = S_INS_LINK;
         CMD_REMOVE:   after_walk = S_REM_READ;
         CMD_RETRIEVE: after_walk = S_RD_WAIT;
         default:      after_walk = S_REPLACE;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      rd_use_in = rd_use_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            pend_in   = STATUS_SUCCESS;
            rd_use_in = 1'b0;
            state_in  = S_FINISH;
            unique case (stat.cmd)
               CMD_INSERT: begin
                  if (stat.pos_gt_count) begin
                     pend_in = STATUS_RANGE_ERROR;
                  end else if (stat.free_avail) begin
                     cmd.alloc = 1'b1;
                     state_in  = S_ALLOC_POP;
                  end else if (stat.mark_avail) begin
                     cmd.alloc = 1'b1;
                     state_in  = S_WALK_START;
                  end else begin
                     pend_in = STATUS_OVERFLOW;
                  end
               end
               CMD_REMOVE: begin
                  if (stat.count_zero) begin
                     pend_in = STATUS_FAIL;
                  end else if (stat.pos_ge_count) begin
                     pend_in = STATUS_RANGE_ERROR;
                  end else begin
                     rd_use_in = 1'b1;
                     state_in  = S_WALK_START;
                  end
               end
               CMD_RETRIEVE: begin
                  if (stat.pos_ge_count) begin
                     pend_in = STATUS_RANGE_ERROR;
                  end else begin
                     rd_use_in = 1'b1;
                     state_in  = S_WALK_START;
                  end
               end
               CMD_REPLACE: begin
                  if (stat.pos_ge_count) begin
                     pend_in = STATUS_RANGE_ERROR;
                  end else begin
                     state_in = S_WALK_START;
                  end
               end
               CMD_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               default: begin
                  pend_in = STATUS_RANGE_ERROR;
               end
            endcase
         end
         S_ALLOC_POP: begin
            cmd.alloc_pop = 1'b1;
            state_in      = S_WALK_START;
         end
         S_WALK_START: begin
            cmd.walk_start = 1'b1;
            state_in       = stat.steps_zero ? after_walk : S_WALK;
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.steps_zero) begin
               state_in = after_walk;
            end
         end
         S_INS_LINK: begin
            cmd.link_wr_slot = 1'b1;
            state_in         = S_INS_FIX;
         end
         S_INS_FIX: begin
            if (stat.pos_zero) begin
               cmd.head_to_slot = 1'b1;
            end else begin
               cmd.link_wr_prev_slot = 1'b1;
            end
            cmd.count_inc = 1'b1;
            state_in      = S_FINISH;
         end
         S_REM_READ: begin
            cmd.link_rd_cur = 1'b1;
            state_in        = S_REM_FIX;
         end
         S_REM_FIX: begin
            // unlink the removed slot from its predecessor or the head
            if (stat.pos_zero) begin
               cmd.head_to_linkq = 1'b1;
            end else begin
               cmd.link_wr_prev_linkq = 1'b1;
            end
            state_in = S_REM_RELEASE;
         end
         S_REM_RELEASE: begin
            cmd.release_cur = 1'b1;
            cmd.count_dec   = 1'b1;
            state_in        = S_FINISH;
         end
         S_RD_WAIT: begin
            state_in = S_FINISH;
         end
         S_REPLACE: begin
            cmd.entry_wr_cur = 1'b1;
            state_in         = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               cmd.status   = pend_ff;
               cmd.rd_use   = rd_use_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff   <= pend_in;
      rd_use_ff <= rd_use_in;
   end

   assign rsp_valid = rsp_valid_ff;

   // one transaction in flight at a time
   `PLL_ASSERT_NEXT(a_accept_blocks, clock, reset, req_valid && req_ready, !req_ready)
   `PLL_ASSERT_IMPL(a_rsp_from_finish, clock, reset, rsp_valid_ff && !$past(rsp_valid_ff), $past(state_ff == S_FINISH))

endmodule

// ===== hdl/positional_linked_list.sv =====
// top level of the positional linked list: controller plus datapath
// errors and clear go from decode straight to the result; other commands first walk to the position
// one transaction at a time: a new request is taken only after the last result has been loaded
// the walk to a position follows one link per cycle; a waiting result holds the next one back
// reset clears list pointers, counts and handshake state; slot stores are not initialised
`include "assert_macros.svh"

module positional_linked_list #(
   parameter int DEPTH       = pll_pkg::DEFAULT_DEPTH,
   parameter int ENTRY_WIDTH = pll_pkg::DEFAULT_ENTRY_WIDTH,
   localparam int CNT_W      = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_command,
   input  logic [CNT_W-1:0]       req_position,
   input  logic [ENTRY_WIDTH-1:0] req_new_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [ENTRY_WIDTH-1:0] rsp_read_value,
   output logic [CNT_W-1:0]       rsp_entry_total,
   output logic                   rsp_is_empty
);
   import pll_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   pll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pll_datapath #(
      .DEPTH       (DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_new_value   (req_new_value),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_total (rsp_entry_total),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule
